// ===== hw/rtl/vpc_pkg.sv =====
// shared types and constants for the velocity pi controller
// no dependencies; used by vpc_cfg, vpc_ctrl, vpc_datapath and the top level
package vpc_pkg;

  localparam int unsigned VEL_W  = 48;  // velocity and error width
  localparam int unsigned GAIN_W = 24;  // multiplier operand width
  localparam int unsigned MAG_W  = 34;  // saturated gain product magnitude
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DATA_W = 32;

  // any product magnitude at or above this lands outside both clamps
  localparam logic [MAG_W-1:0] SAT_MAG = MAG_W'(64'h2_0000_0000);

  // register indexes
  localparam logic [IDX_W-1:0] REG_ACCEL_OFFSET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASE_SPEED      = 3'd1;
  localparam logic [IDX_W-1:0] REG_VEL_REFERENCE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KP_GAIN         = 3'd3;
  localparam logic [IDX_W-1:0] REG_KI_GAIN         = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT    = 3'd6;

  // reset values
  localparam logic [8:0]         RST_ACCEL_OFFSET   = 9'd0;
  localparam logic [7:0]         RST_BASE_SPEED     = 8'd60;
  localparam logic signed [31:0] RST_VEL_REFERENCE  = 32'sd0;
  localparam logic [23:0]        RST_KP_GAIN        = 24'd6553600;
  localparam logic [15:0]        RST_KI_GAIN        = 16'd6554;
  localparam logic [30:0]        RST_INTEGRAL_LIMIT = 31'd33554432;
  localparam logic [30:0]        RST_OUTPUT_LIMIT   = 31'd503316480;

  typedef struct packed {
    logic [8:0]         accel_offset;
    logic [7:0]         base_speed;
    logic signed [31:0] velocity_reference;
    logic [23:0]        kp_gain;
    logic [15:0]        ki_gain;
    logic [30:0]        integral_limit;
    logic [30:0]        output_limit;
  } cfg_t;

  typedef struct packed {
    logic vel_load;
    logic err_load;
    logic mag_load;
    logic mul_hi;
    logic mul_kp;
    logic prod_load;
    logic acc_load;
    logic imag_load;
    logic int_load;
    logic pmag_load;
    logic corr_load;
    logic out_load;
  } cmd_t;

endpackage

// ===== hw/rtl/vpc_cfg.sv =====
// configuration register bank, written through the cfg beat channel
// depends on vpc_pkg for the register indexes, reset values and cfg_t
module vpc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vpc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vpc_pkg::DATA_W-1:0]  cfg_data,
  output vpc_pkg::cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_offset       <= vpc_pkg::RST_ACCEL_OFFSET;
      cfg.base_speed         <= vpc_pkg::RST_BASE_SPEED;
      cfg.velocity_reference <= vpc_pkg::RST_VEL_REFERENCE;
      cfg.kp_gain            <= vpc_pkg::RST_KP_GAIN;
      cfg.ki_gain            <= vpc_pkg::RST_KI_GAIN;
      cfg.integral_limit     <= vpc_pkg::RST_INTEGRAL_LIMIT;
      cfg.output_limit       <= vpc_pkg::RST_OUTPUT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vpc_pkg::REG_ACCEL_OFFSET:   cfg.accel_offset       <= cfg_data[8:0];
        vpc_pkg::REG_BASE_SPEED:     cfg.base_speed         <= cfg_data[7:0];
        vpc_pkg::REG_VEL_REFERENCE:  cfg.velocity_reference <= $signed(cfg_data[31:0]);
        vpc_pkg::REG_KP_GAIN:        cfg.kp_gain            <= cfg_data[23:0];
        vpc_pkg::REG_KI_GAIN:        cfg.ki_gain            <= cfg_data[15:0];
        vpc_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit     <= cfg_data[30:0];
        vpc_pkg::REG_OUTPUT_LIMIT:   cfg.output_limit       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vpc_ctrl.sv =====
// sequencer for one controller step: drives the datapath load and select strobes
// depends on vpc_pkg for cmd_t
module vpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vpc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_MAG, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_COR, ST_FIN
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.vel_load = in_valid && in_ready;
      ST_ERR:  cmd.err_load = 1'b1;
      ST_MAG:  cmd.mag_load = 1'b1;
      ST_M0: begin
        cmd.prod_load = 1'b1;
      end
      ST_M1: begin
        cmd.acc_load  = 1'b1;
        cmd.prod_load = 1'b1;
        cmd.mul_hi    = 1'b1;
      end
      ST_M2: begin
        cmd.imag_load = 1'b1;
        cmd.prod_load = 1'b1;
        cmd.mul_kp    = 1'b1;
      end
      ST_M3: begin
        cmd.acc_load  = 1'b1;
        cmd.prod_load = 1'b1;
        cmd.mul_hi    = 1'b1;
        cmd.mul_kp    = 1'b1;
        cmd.int_load  = 1'b1;
      end
      ST_M4:   cmd.pmag_load = 1'b1;
      ST_COR:  cmd.corr_load = 1'b1;
      ST_FIN:  cmd.out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_ERR;
            in_ready <= 1'b0;
          end
        end
        ST_ERR: state <= ST_MAG;
        ST_MAG: state <= ST_M0;
        ST_M0:  state <= ST_M1;
        ST_M1:  state <= ST_M2;
        ST_M2:  state <= ST_M3;
        ST_M3:  state <= ST_M4;
        ST_M4:  state <= ST_COR;
        ST_COR: state <= ST_FIN;
        ST_FIN: begin
          // hold the finished step until the output register frees up
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/vpc_datapath.sv =====
// velocity integrator, shared 24x24 gain multiplier, clamps and output register
// depends on vpc_pkg for cfg_t, cmd_t and the datapath widths
module vpc_datapath #(
  parameter int unsigned FRAC_BITS  = 24,
  parameter int unsigned ACCEL_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vpc_pkg::cfg_t         cfg,
  input  vpc_pkg::cmd_t         cmd,
  input  logic [ACCEL_BITS-1:0] accel_sample,
  input  logic                  clear_velocity,
  output logic [7:0]            left_speed,
  output logic [7:0]            right_speed,
  output logic signed [31:0]    correction,
  output logic [15:0]           led_word
);

  localparam int unsigned VW = vpc_pkg::VEL_W;
  localparam int unsigned GW = vpc_pkg::GAIN_W;
  localparam int unsigned MW = vpc_pkg::MAG_W;
  // time step 0.0001 rounded to nearest
  localparam longint unsigned VEL_STEP = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam int unsigned STEP_W = $clog2(VEL_STEP + 1);
  localparam int unsigned VP_W   = ACCEL_BITS + STEP_W + 2;
  // motor sum width: covers base << FRAC_BITS and the full correction range
  localparam int unsigned BW = ((FRAC_BITS + 8 > 32) ? FRAC_BITS + 8 : 32) + 2;
  localparam int unsigned SW = MW + 2;  // clamp input width

  localparam logic signed [VW-1:0] S48_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] S48_MIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] velocity;
  logic signed [VW-1:0] err;
  logic                 eneg;
  logic [VW-1:0]        emag;
  logic [2*GW-1:0]      prod;
  logic [2*GW-1:0]      acc;
  logic [MW-1:0]        imag;
  logic [MW-1:0]        pmag;
  logic signed [31:0]   integral;
  logic signed [31:0]   corr;

  function automatic logic signed [VW-1:0] sat48(input logic signed [VW:0] x);
    if (x[VW] != x[VW-1]) return x[VW] ? S48_MIN : S48_MAX;
    return x[VW-1:0];
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [SW-1:0] x,
                                                   input logic [30:0] lim);
    logic signed [SW-1:0] limx;
    limx = $signed(SW'(lim));
    if (x > limx) return 32'(limx);
    if (x < -limx) return 32'(-limx);
    return x[31:0];
  endfunction

  function automatic logic [7:0] motor(input logic signed [BW-1:0] x);
    if (x[BW-1]) return 8'd0;
    if (|x[BW-2:FRAC_BITS+8]) return 8'hff;
    return x[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // velocity update, done on the accepting edge
  logic signed [ACCEL_BITS:0]   accel_diff;
  logic signed [VP_W-1:0]       vel_prod;
  logic signed [VW-1:0]         vel_base;
  logic signed [VW:0]           vel_sum;

  assign accel_diff = $signed({1'b0, accel_sample}) -
                      $signed({1'b0, ACCEL_BITS'(cfg.accel_offset)});
  assign vel_prod   = accel_diff * $signed({1'b0, STEP_W'(VEL_STEP)});
  assign vel_base   = clear_velocity ? '0 : velocity;
  assign vel_sum    = (VW+1)'(vel_base) + (VW+1)'(vel_prod);

  logic signed [VW:0] err_diff;
  assign err_diff = (VW+1)'(cfg.velocity_reference) - (VW+1)'(velocity);

  // shared multiplier: one 24-bit half of |err| times one gain
  logic [GW-1:0]   mul_a;
  logic [GW-1:0]   mul_b;
  logic [3*GW-1:0] full;
  logic [MW-1:0]   mag_sat;

  assign mul_a = cmd.mul_hi ? emag[2*GW-1:GW] : emag[GW-1:0];
  assign mul_b = cmd.mul_kp ? cfg.kp_gain : GW'(cfg.ki_gain);
  assign full  = {{GW{1'b0}}, acc} + {prod, {GW{1'b0}}};
  // product >> 16, saturated where it already exceeds either clamp
  assign mag_sat = (|full[3*GW-1:49]) ? vpc_pkg::SAT_MAG : {1'b0, full[48:16]};

  logic signed [SW-1:0] iterm;
  logic signed [SW-1:0] pterm;
  logic signed [SW-1:0] isum;
  logic signed [SW-1:0] csum;

  assign iterm = eneg ? -$signed({2'b00, imag}) : $signed({2'b00, imag});
  assign pterm = eneg ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});
  assign isum  = SW'(integral) + iterm;
  assign csum  = SW'(integral) + pterm;

  // result formatting
  logic signed [BW-1:0] bfix;
  logic signed [BW-1:0] lsum;
  logic signed [BW-1:0] rsum;
  logic [31:0]          cmag;
  logic [15:0]          lmag;

  assign bfix = $signed(BW'(cfg.base_speed) << FRAC_BITS);
  assign lsum = bfix + BW'(corr);
  assign rsum = bfix - BW'(corr);
  assign cmag = corr[31] ? 32'(-corr) : 32'(corr);
  assign lmag = 16'(cmag >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity <= '0;
      integral <= '0;
    end else begin
      if (cmd.vel_load) velocity <= sat48(vel_sum);
      if (cmd.int_load) integral <= clamp_sym(isum, cfg.integral_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      err  <= sat48(err_diff);
    end
    if (cmd.mag_load) begin
      eneg <= err[VW-1];
      emag <= err[VW-1] ? VW'(-err) : VW'(err);
    end
    if (cmd.prod_load) prod <= mul_a * mul_b;
    if (cmd.acc_load)  acc  <= prod;
    if (cmd.imag_load) imag <= mag_sat;
    if (cmd.pmag_load) pmag <= mag_sat;
    if (cmd.corr_load) corr <= clamp_sym(csum, cfg.output_limit);
    if (cmd.out_load) begin
      left_speed  <= motor(lsum);
      right_speed <= motor(rsum);
      correction  <= corr;
      led_word    <= corr[31] ? {1'b1, lmag[14:0]} : lmag;
    end
  end

endmodule

// ===== hw/rtl/velocity_pi_controller_core.sv =====
// top level of the velocity pi controller: config bank, sequencer and datapath
// depends on vpc_pkg, vpc_cfg, vpc_ctrl and vpc_datapath
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | accel_sample, clear_velocity
//   out     | out_valid/out_ready  | left_speed, right_speed, correction, led_word
//
// a sample passes from its accepting beat through the sequencer states err, mag, m0-m4, cor
// and fin to out_valid; no new sample is taken before then, as the sequencer walks one item
// through the single shared 24x24 gain multiplier (four partial products) and the two clamps.
// synchronous reset clears velocity, integral and the registers to their defaults.
// a result held by out_ready low stalls the next item only at its final step;
// cfg_ready is always high.
module velocity_pi_controller_core #(
  parameter int unsigned FRAC_BITS  = 24,
  parameter int unsigned ACCEL_BITS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vpc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vpc_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ACCEL_BITS-1:0]       accel_sample,
  input  logic                        clear_velocity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  left_speed,
  output logic [7:0]                  right_speed,
  output logic signed [31:0]          correction,
  output logic [15:0]                 led_word
);

  vpc_pkg::cfg_t cfg;
  vpc_pkg::cmd_t cmd;

  vpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vpc_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .ACCEL_BITS (ACCEL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .accel_sample   (accel_sample),
    .clear_velocity (clear_velocity),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .correction     (correction),
    .led_word       (led_word)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a step is in progress");

  a_corr_symmetric: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> correction != 32'h8000_0000)
    else $error("correction outside the symmetric clamp");

  a_led_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> led_word[15] == correction[31])
    else $error("led sign bit disagrees with correction");

  a_speed_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !correction[31] |-> left_speed >= right_speed)
    else $error("left speed below right speed for a positive correction");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for velocity_pi_controller_core: directed table, then random samples
// against a cycle-free model of the pi step; depends on vpc_pkg and the core rtl
module testbench;
  import vpc_pkg::*;

  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam longint      ACCEL_STEP = ((longint'(1) <<< FRAC_BITS) + 5000) / 10000;
  localparam longint      S48_MAX    = 64'sh7FFF_FFFF_FFFF;
  localparam longint      S48_MIN    = -S48_MAX - 1;
  localparam bit [63:0]   PROD_CAP   = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned BATCHES        = 5;
  localparam int unsigned BATCH_ITEMS    = 122;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 30;

  localparam int unsigned GAP_PLAN   [3] = '{12, 52, 0};
  localparam int unsigned STALL_PLAN [3] = '{52, 12, 0};

  typedef struct packed {
    logic [7:0]         left;
    logic [7:0]         right;
    logic signed [31:0] corr;
    logic [15:0]        led;
  } drive_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      data;
    logic [8:0]       sample;
    logic             clr;
    drive_t           known;
  } dir_row_t;

  localparam drive_t NO_DRIVE = '0;
  localparam int unsigned SCRIPT_LEN = 39;

  // known rows: clear set where velocity must start from rest
  localparam dir_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd0,   1'b0, '{8'd60, 8'd60, 32'sd0, 16'h0000}},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd1,   1'b1,
      '{8'd59, 8'd60, -32'sd167967, 16'h8000}},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd511, 1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_ACCEL_OFFSET,   32'd511,      9'd0,   1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd0,   1'b1, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd511, 1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_VEL_REFERENCE,  32'h7FFF_FFFF, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd90, 8'd30, 32'sd503316480, 16'd30}},
    '{ROW_WRITE,   REG_BASE_SPEED,     32'd255,      9'd0,   1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd255, 8'd225, 32'sd503316480, 16'd30}},
    '{ROW_WRITE,   REG_VEL_REFERENCE,  32'h8000_0000, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd225, 8'd255, -32'sd503316480, 16'h801E}},
    '{ROW_WRITE,   REG_BASE_SPEED,     32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd0, 8'd30, -32'sd503316480, 16'h801E}},
    '{ROW_WRITE,   REG_BASE_SPEED,     32'd60,       9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_OUTPUT_LIMIT,   32'h7FFF_FFFF, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd0, 8'd187, -32'sd2147483647, 16'h807F}},
    '{ROW_WRITE,   REG_VEL_REFERENCE,  32'h7FFF_FFFF, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1,
      '{8'd187, 8'd0, 32'sd2147483647, 16'h007F}},
    '{ROW_WRITE,   REG_OUTPUT_LIMIT,   32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd511, 1'b1, '{8'd60, 8'd60, 32'sd0, 16'h0000}},
    '{ROW_WRITE,   REG_OUTPUT_LIMIT,   32'd503316480, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_KP_GAIN,        32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_KI_GAIN,        32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd300, 1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_INTEGRAL_LIMIT, 32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_KNOWN,   REG_UNUSED,         32'd0,        9'd300, 1'b0, '{8'd60, 8'd60, 32'sd0, 16'h0000}},
    '{ROW_WRITE,   REG_KP_GAIN,        32'hFF_FFFF,  9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_KI_GAIN,        32'hFFFF,     9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_VEL_REFERENCE,  32'd0,        9'd0,   1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_ACCEL_OFFSET,   32'd256,      9'd0,   1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd0,   1'b1, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd511, 1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd255, 1'b0, NO_DRIVE},
    '{ROW_WRITE,   REG_UNUSED,         32'hFFFF_FFFF, 9'd0,  1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd256, 1'b0, NO_DRIVE},
    '{ROW_PREDICT, REG_UNUSED,         32'd0,        9'd128, 1'b1, NO_DRIVE}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [8:0]         accel_sample;
  logic               clear_velocity;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         left_speed;
  logic [7:0]         right_speed;
  logic signed [31:0] correction;
  logic [15:0]        led_word;

  velocity_pi_controller_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .accel_sample   (accel_sample),
    .clear_velocity (clear_velocity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .correction     (correction),
    .led_word       (led_word)
  );

  always #2 clk = ~clk;

  // model state and register copy
  cfg_t        ctl;
  longint      vel_acc;
  longint      err_sum;
  drive_t      drive_due [$];
  int unsigned bad_beats;
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_req;

  function automatic longint sat48(longint x);
    if (x > S48_MAX) return S48_MAX;
    if (x < S48_MIN) return S48_MIN;
    return x;
  endfunction

  function automatic longint trim(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic [7:0] motor_level(longint fx);
    longint whole;
    if (fx < 0) return 8'd0;
    whole = fx >>> FRAC_BITS;
    return (whole > 255) ? 8'd255 : whole[7:0];
  endfunction

  // one pi step: integrate the sample, then gains, clamps and motor split
  function automatic drive_t next_drive(logic [8:0] s, logic clr);
    longint    err;
    longint    pterm;
    longint    corr;
    longint    base_fx;
    bit        eneg;
    bit [63:0] emag;
    bit [63:0] imag;
    bit [63:0] pmag;
    bit [63:0] lmag;
    drive_t    r;
    if (clr) vel_acc = 0;
    vel_acc = sat48(vel_acc + (longint'(s) - longint'(ctl.accel_offset)) * ACCEL_STEP);
    err = sat48(longint'($signed(ctl.velocity_reference)) - vel_acc);
    eneg = err < 0;
    emag = eneg ? 64'(-err) : 64'(err);
    imag = (emag * 64'(ctl.ki_gain)) >> GAIN_FRAC;
    err_sum = trim(err_sum + (eneg ? -longint'(imag) : longint'(imag)),
                   longint'(ctl.integral_limit));
    if (ctl.kp_gain != 0 && emag > PROD_CAP / 64'(ctl.kp_gain))
      pmag = PROD_CAP;
    else
      pmag = (emag * 64'(ctl.kp_gain)) >> GAIN_FRAC;
    pterm = eneg ? -longint'(pmag) : longint'(pmag);
    corr = trim(err_sum + pterm, longint'(ctl.output_limit));
    lmag = (corr < 0 ? 64'(-corr) : 64'(corr)) >> FRAC_BITS;
    base_fx = longint'(ctl.base_speed) <<< FRAC_BITS;
    r.left = motor_level(base_fx + corr);
    r.right = motor_level(base_fx - corr);
    r.corr = corr[31:0];
    r.led = (corr < 0) ? {1'b1, lmag[14:0]} : lmag[15:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_level(int unsigned width, logic [31:0] dflt);
    logic [31:0] top;
    top = 32'hFFFF_FFFF >> (32 - width);
    case ($urandom_range(7))
      0: return '0;
      1: return top;
      2, 3: return dflt;
      default: return ($urandom & top) >> $urandom_range(width - 1);
    endcase
  endfunction

  task automatic report_bad(input string msg);
    bad_beats++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // called at a falling edge; returns at the falling edge after the beat, valid left high
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACCEL_OFFSET:   ctl.accel_offset = data[8:0];
      REG_BASE_SPEED:     ctl.base_speed = data[7:0];
      REG_VEL_REFERENCE:  ctl.velocity_reference = data;
      REG_KP_GAIN:        ctl.kp_gain = data[23:0];
      REG_KI_GAIN:        ctl.ki_gain = data[15:0];
      REG_INTEGRAL_LIMIT: ctl.integral_limit = data[30:0];
      REG_OUTPUT_LIMIT:   ctl.output_limit = data[30:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after the beat, valid left high
  task automatic offer_sample(input logic [8:0] s, input logic clr);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    accel_sample   <= s;
    clear_velocity <= clr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        report_bad($sformatf("result beat with nothing pending, correction %0d", correction));
      end else begin
        want = drive_due.pop_front();
        if (left_speed !== want.left)
          report_bad($sformatf("left_speed %0d, want %0d", left_speed, want.left));
        if (right_speed !== want.right)
          report_bad($sformatf("right_speed %0d, want %0d", right_speed, want.right));
        if (correction !== want.corr)
          report_bad($sformatf("correction %0d, want %0d", correction, want.corr));
        if (led_word !== want.led)
          report_bad($sformatf("led_word %h, want %h", led_word, want.led));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_row_t    row;
    drive_t      due;
    logic [8:0]  s;
    logic        clr;
    logic [31:0] mag;
    int          near;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    accel_sample   = '0;
    clear_velocity = 1'b0;
    hold_req       = 1'b0;
    bad_beats      = 0;
    gap_pct        = GAP_PLAN[0];
    stall_pct      = STALL_PLAN[0];
    vel_acc        = 0;
    err_sum        = 0;
    ctl = '{accel_offset: RST_ACCEL_OFFSET, base_speed: RST_BASE_SPEED,
            velocity_reference: RST_VEL_REFERENCE, kp_gain: RST_KP_GAIN,
            ki_gain: RST_KI_GAIN, integral_limit: RST_INTEGRAL_LIMIT,
            output_limit: RST_OUTPUT_LIMIT};
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        cfg_valid <= 1'b0;
        offer_sample(row.sample, row.clr);
        due = next_drive(row.sample, row.clr);
        drive_due.push_back(row.kind == ROW_KNOWN ? row.known : due);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = GAP_PLAN[ph];
      stall_pct = STALL_PLAN[ph];
      for (int b = 0; b < BATCHES; b++) begin
        drain();
        write_reg(REG_ACCEL_OFFSET, pick_level(9, 32'(RST_ACCEL_OFFSET)));
        write_reg(REG_BASE_SPEED, pick_level(8, 32'(RST_BASE_SPEED)));
        write_reg(REG_KP_GAIN, pick_level(24, 32'(RST_KP_GAIN)));
        write_reg(REG_KI_GAIN, pick_level(16, 32'(RST_KI_GAIN)));
        write_reg(REG_INTEGRAL_LIMIT, pick_level(31, 32'(RST_INTEGRAL_LIMIT)));
        write_reg(REG_OUTPUT_LIMIT, pick_level(31, 32'(RST_OUTPUT_LIMIT)));
        case ($urandom_range(7))
          0: mag = 32'h7FFF_FFFF;
          1: mag = 32'h8000_0000;
          2, 3: mag = '0;
          default: begin
            mag = $urandom >> $urandom_range(31, 1);
            if ($urandom_range(1)) mag = -mag;
          end
        endcase
        write_reg(REG_VEL_REFERENCE, mag);
        if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        // long receiver hold-off while samples keep coming, so the input backs up
        if (ph == 2 && b == 0) hold_req = 1'b1;
        repeat (BATCH_ITEMS) begin
          // mostly samples close to the offset so velocity drifts slowly
          if ($urandom_range(3) == 0) begin
            s = $urandom_range(511);
          end else begin
            near = int'(ctl.accel_offset) + int'($urandom_range(12)) - 6;
            s = (near < 0) ? 9'd0 : (near > 511) ? 9'd511 : near[8:0];
          end
          clr = ($urandom_range(31) == 0);
          offer_sample(s, clr);
          drive_due.push_back(next_drive(s, clr));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_beats == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== velocity_pi_controller_core.f =====
hw/rtl/vpc_pkg.sv
hw/rtl/vpc_cfg.sv
hw/rtl/vpc_ctrl.sv
hw/rtl/vpc_datapath.sv
hw/rtl/velocity_pi_controller_core.sv
tb/testbench.sv
